### rtl/cte_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Capability table engine package
// Shared types, codes and the checksum step of the capability table.
// ----------------------------------------------------------------------------
package cte_pkg;

    localparam logic [1:0] OP_CREATE  = 2'd0;
    localparam logic [1:0] OP_CHECK   = 2'd1;
    localparam logic [1:0] OP_DESTROY = 2'd2;
    localparam logic [1:0] OP_REVOKE  = 2'd3;

    localparam logic [3:0] ST_OK        = 4'd0;
    localparam logic [3:0] ST_NOT_FOUND = 4'd1;
    localparam logic [3:0] ST_INACTIVE  = 4'd2;
    localparam logic [3:0] ST_INTEGRITY = 4'd3;
    localparam logic [3:0] ST_WRONG_OWN = 4'd4;
    localparam logic [3:0] ST_NO_RIGHTS = 4'd5;
    localparam logic [3:0] ST_FULL      = 4'd6;
    localparam logic [3:0] ST_IMMORTAL  = 4'd7;
    localparam logic [3:0] ST_NONE_REV  = 4'd8;

    localparam logic [1:0] ENT_ACTIVE  = 2'd1;
    localparam logic [1:0] ENT_REVOKED = 2'd3;

    localparam int RIGHT_IMMORTAL = 14;
    localparam int RIGHT_REVOKE   = 4;

    localparam logic [63:0] HASH_ADD      = 64'h0000_0000_9e37_79b9;
    localparam logic [63:0] COUNTER_RESET = 64'd1000000;

    typedef struct packed {
        logic [1:0]  status;
        logic [63:0] id;
        logic [3:0]  kind;
        logic [63:0] object;
        logic [15:0] rights;
        logic [31:0] owner;
        logic [31:0] creator;
        logic [63:0] created;
        logic [63:0] checksum;
    } entry_t;

    typedef enum logic [3:0] {
        S_IDLE, S_FIND, S_FIND_WAIT, S_HASH, S_JUDGE,
        S_SCAN, S_SCAN_WAIT, S_SCAN_HASH, S_SCAN_WB, S_DONE
    } state_t;

    function automatic logic [63:0] mix(input logic [63:0] s, input logic [63:0] v);
        mix = s ^ (v + HASH_ADD + (s << 6) + (s >> 2));
    endfunction

endpackage
`default_nettype wire

### rtl/cte_table.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Capability table memory
// Synchronous table with one read port and one write port, a registered read and a
// valid bit per entry so that unwritten entries read as zeroed, revoked entries.
// ----------------------------------------------------------------------------
module cte_table #(
    parameter int NUM_ENTRIES = 64,
    parameter int IW = 6
) (
    input  wire               aclk,
    input  wire               aresetn,
    input  wire [IW-1:0]      rd_addr,
    output cte_pkg::entry_t   rd_data,
    input  wire               wr_en,
    input  wire [IW-1:0]      wr_addr,
    input  cte_pkg::entry_t   wr_data
);

    cte_pkg::entry_t mem [NUM_ENTRIES];
    logic [NUM_ENTRIES-1:0] valid_reg;
    cte_pkg::entry_t raw_reg;
    logic vld_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        raw_reg <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            vld_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                valid_reg[wr_addr] <= 1'b1;
            end
            vld_reg <= valid_reg[rd_addr];
        end
    end

    always_comb begin
        if (vld_reg) begin
            rd_data = raw_reg;
        end else begin
            rd_data = '0;
            rd_data.status = cte_pkg::ENT_REVOKED;
        end
    end

endmodule
`default_nettype wire

### rtl/capability_table_engine_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Capability table engine
// Create, check, destroy and revoke requests on a table of capabilities.
// ----------------------------------------------------------------------------
// One request is worked at a time. Each request first scans the table one
// entry at a time through the table's read port until the free slot or the id
// is found. Create, check and revoke then run the checksum chain over the entry.
// Revoke, when its own capability passes the checks, adds a second pass that
// reads every entry and rehashes and writes back each entry whose rights it
// cuts. The result waits in an output register while the next request is
// taken; a request stalls at its end only while the previous result is still
// unaccepted.
module capability_table_engine_core #(
    parameter int NUM_ENTRIES = 64
) (
    input  wire          aclk,
    input  wire          aresetn,
    input  wire          s_tvalid,
    output logic         s_tready,
    // operation, cap_id, object_type, target object, rights, target pid,
    // calling pid, now, random_word
    input  wire  [343:0] s_tdata,
    output logic         m_tvalid,
    input  wire          m_tready,
    // status, created id, granted, changed entry total
    output logic [79:0]  m_tdata
);

    localparam int IW = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
    localparam int CW = IW + 1;

    cte_pkg::state_t state_reg, state_next;
    logic [341:0] req_reg, req_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [2:0] step_reg, step_next;
    logic [63:0] hash_reg, hash_next;
    logic [63:0] ctr_reg, ctr_next;
    logic [6:0] cnt_reg, cnt_next;
    logic [3:0] stat_reg, stat_next;
    logic [63:0] nid_reg, nid_next;
    cte_pkg::entry_t ent_reg, ent_next;
    logic out_v_reg, out_v_next;
    logic [79:0] out_reg, out_next;

    logic [1:0] f_op;
    logic [63:0] f_cid, f_obj, f_now, f_rnd;
    logic [3:0] f_kind;
    logic [15:0] f_rts;
    logic [31:0] f_own, f_call;

    logic [IW-1:0] rd_addr;
    cte_pkg::entry_t rd_data, wr_data;
    logic wr_en;
    logic [63:0] hv;

    assign f_op = req_reg[1:0];
    assign f_cid = req_reg[65:2];
    assign f_kind = req_reg[69:66];
    assign f_obj = req_reg[133:70];
    assign f_rts = req_reg[149:134];
    assign f_own = req_reg[181:150];
    assign f_call = req_reg[213:182];
    assign f_now = req_reg[277:214];
    assign f_rnd = req_reg[341:278];

    cte_table #(.NUM_ENTRIES(NUM_ENTRIES), .IW(IW)) u_table (
        .aclk(aclk), .aresetn(aresetn), .rd_addr(rd_addr), .rd_data(rd_data),
        .wr_en(wr_en), .wr_addr(idx_reg[IW-1:0]), .wr_data(wr_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= cte_pkg::S_IDLE;
            ctr_reg <= cte_pkg::COUNTER_RESET;
            out_v_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            ctr_reg <= ctr_next;
            out_v_reg <= out_v_next;
        end
        req_reg <= req_next;
        idx_reg <= idx_next;
        step_reg <= step_next;
        hash_reg <= hash_next;
        cnt_reg <= cnt_next;
        stat_reg <= stat_next;
        nid_reg <= nid_next;
        ent_reg <= ent_next;
        out_reg <= out_next;
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata = out_reg;

    always_comb begin
        unique case (step_reg)
            3'd0: hv = ent_reg.id;
            3'd1: hv = {60'd0, ent_reg.kind};
            3'd2: hv = ent_reg.object;
            3'd3: hv = {48'd0, ent_reg.rights};
            3'd4: hv = {32'd0, ent_reg.owner};
            default: hv = ent_reg.created;
        endcase
    end

    always_comb begin
        state_next = state_reg;
        req_next = req_reg;
        idx_next = idx_reg;
        step_next = step_reg;
        hash_next = hash_reg;
        ctr_next = ctr_reg;
        cnt_next = cnt_reg;
        stat_next = stat_reg;
        nid_next = nid_reg;
        ent_next = ent_reg;
        out_v_next = out_v_reg;
        out_next = out_reg;
        rd_addr = idx_reg[IW-1:0];
        wr_en = 1'b0;
        wr_data = ent_reg;
        s_tready = 1'b0;
        if (m_tready) begin
            out_v_next = 1'b0;
        end
        unique case (state_reg)
            cte_pkg::S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    req_next = s_tdata[341:0];
                    idx_next = '0;
                    cnt_next = '0;
                    nid_next = '0;
                    state_next = cte_pkg::S_FIND;
                end
            end
            cte_pkg::S_FIND: begin
                if (idx_reg == CW'(NUM_ENTRIES) ||
                    (f_op != cte_pkg::OP_CREATE && f_cid == 64'd0)) begin
                    stat_next = (f_op == cte_pkg::OP_CREATE) ? cte_pkg::ST_FULL
                                                             : cte_pkg::ST_NOT_FOUND;
                    state_next = cte_pkg::S_DONE;
                end else begin
                    state_next = cte_pkg::S_FIND_WAIT;
                end
            end
            cte_pkg::S_FIND_WAIT: begin
                ent_next = rd_data;
                step_next = '0;
                hash_next = '0;
                state_next = cte_pkg::S_FIND;
                if (f_op == cte_pkg::OP_CREATE) begin
                    if (rd_data.status == cte_pkg::ENT_REVOKED) begin
                        ent_next.status = cte_pkg::ENT_ACTIVE;
                        ent_next.id = ctr_reg ^ f_rnd;
                        ent_next.kind = f_kind;
                        ent_next.object = f_obj;
                        ent_next.rights = f_rts;
                        ent_next.owner = f_own;
                        ent_next.creator = f_call;
                        ent_next.created = f_now;
                        nid_next = ctr_reg ^ f_rnd;
                        ctr_next = ctr_reg + 64'd1;
                        state_next = cte_pkg::S_HASH;
                    end else begin
                        idx_next = idx_reg + CW'(1);
                    end
                end else if (rd_data.id == f_cid) begin
                    state_next = (f_op == cte_pkg::OP_DESTROY) ? cte_pkg::S_JUDGE
                                                               : cte_pkg::S_HASH;
                end else begin
                    idx_next = idx_reg + CW'(1);
                end
            end
            cte_pkg::S_HASH: begin
                hash_next = cte_pkg::mix(hash_reg, hv);
                step_next = step_reg + 3'd1;
                if (step_reg == 3'd5) begin
                    state_next = cte_pkg::S_JUDGE;
                end
            end
            cte_pkg::S_JUDGE: begin
                stat_next = cte_pkg::ST_OK;
                state_next = cte_pkg::S_DONE;
                unique case (f_op)
                    cte_pkg::OP_CREATE: begin
                        wr_data.checksum = hash_reg;
                        wr_en = 1'b1;
                    end
                    cte_pkg::OP_DESTROY: begin
                        if (ent_reg.rights[cte_pkg::RIGHT_IMMORTAL]) begin
                            stat_next = cte_pkg::ST_IMMORTAL;
                        end else begin
                            wr_data.status = cte_pkg::ENT_REVOKED;
                            wr_data.id = '0;
                            wr_data.rights = '0;
                            wr_data.owner = '0;
                            wr_data.object = '0;
                            wr_en = 1'b1;
                        end
                    end
                    default: begin
                        if (ent_reg.status != cte_pkg::ENT_ACTIVE) begin
                            stat_next = cte_pkg::ST_INACTIVE;
                        end else if (ent_reg.checksum != hash_reg) begin
                            stat_next = cte_pkg::ST_INTEGRITY;
                            wr_data.status = cte_pkg::ENT_REVOKED;
                            wr_en = 1'b1;
                        end else if (ent_reg.owner != f_call) begin
                            stat_next = cte_pkg::ST_WRONG_OWN;
                        end else if (f_op == cte_pkg::OP_CHECK &&
                                     (ent_reg.rights & f_rts) != f_rts) begin
                            stat_next = cte_pkg::ST_NO_RIGHTS;
                        end else if (f_op == cte_pkg::OP_REVOKE &&
                                     !ent_reg.rights[cte_pkg::RIGHT_REVOKE]) begin
                            stat_next = cte_pkg::ST_NO_RIGHTS;
                        end else if (f_op == cte_pkg::OP_REVOKE) begin
                            idx_next = '0;
                            state_next = cte_pkg::S_SCAN;
                        end
                    end
                endcase
            end
            cte_pkg::S_SCAN: begin
                if (idx_reg == CW'(NUM_ENTRIES)) begin
                    if (cnt_reg == 7'd0) begin
                        stat_next = cte_pkg::ST_NONE_REV;
                    end
                    state_next = cte_pkg::S_DONE;
                end else begin
                    state_next = cte_pkg::S_SCAN_WAIT;
                end
            end
            cte_pkg::S_SCAN_WAIT: begin
                ent_next = rd_data;
                ent_next.rights = rd_data.rights & ~f_rts;
                step_next = '0;
                hash_next = '0;
                if (rd_data.owner == f_own && rd_data.status == cte_pkg::ENT_ACTIVE &&
                    (rd_data.object == 64'd0 || rd_data.creator == f_call) &&
                    !rd_data.rights[cte_pkg::RIGHT_IMMORTAL]) begin
                    state_next = cte_pkg::S_SCAN_HASH;
                end else begin
                    idx_next = idx_reg + CW'(1);
                    state_next = cte_pkg::S_SCAN;
                end
            end
            cte_pkg::S_SCAN_HASH: begin
                hash_next = cte_pkg::mix(hash_reg, hv);
                step_next = step_reg + 3'd1;
                if (step_reg == 3'd5) begin
                    state_next = cte_pkg::S_SCAN_WB;
                end
            end
            cte_pkg::S_SCAN_WB: begin
                wr_data.checksum = hash_reg;
                if (ent_reg.rights == 16'd0) begin
                    wr_data.status = cte_pkg::ENT_REVOKED;
                end
                wr_en = 1'b1;
                if (cnt_reg != 7'd127) begin
                    cnt_next = cnt_reg + 7'd1;
                end
                idx_next = idx_reg + CW'(1);
                state_next = cte_pkg::S_SCAN;
            end
            cte_pkg::S_DONE: begin
                if (!out_v_reg || m_tready) begin
                    out_v_next = 1'b1;
                    out_next = {4'd0,
                                (f_op == cte_pkg::OP_REVOKE &&
                                 (stat_reg == cte_pkg::ST_OK ||
                                  stat_reg == cte_pkg::ST_NONE_REV)) ? cnt_reg : 7'd0,
                                stat_reg == cte_pkg::ST_OK,
                                (stat_reg == cte_pkg::ST_OK) ? nid_reg : 64'd0,
                                stat_reg};
                    state_next = cte_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = cte_pkg::S_IDLE;
            end
        endcase
    end

    logic unused_tail;
    assign unused_tail = ^s_tdata[343:342];

endmodule
`default_nettype wire

### verif/cte_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Capability table engine checker
// Watches both stream channels of the capability table engine. It keeps its
// own copy of the table, works out the expected response for every accepted
// request and compares each accepted response with the oldest expectation.
// ----------------------------------------------------------------------------
module cte_checker #(
    parameter int NUM_ENTRIES = 64
) (
    input  wire          aclk,
    input  wire          aresetn,
    input  wire          s_tvalid,
    input  wire          s_tready,
    input  wire  [343:0] s_tdata,
    input  wire          m_tvalid,
    input  wire          m_tready,
    input  wire  [79:0]  m_tdata,
    output int           fail_count,
    output int           pending
);

    typedef struct packed {
        logic [6:0]  revoked;
        logic        granted;
        logic [63:0] new_id;
        logic [3:0]  status;
    } answer_t;

    cte_pkg::entry_t cap_table [NUM_ENTRIES];
    logic [63:0]     next_serial;
    answer_t         answer_q [$];

    function automatic logic [63:0] hash_step(logic [63:0] s, logic [63:0] v);
        return s ^ (v + cte_pkg::HASH_ADD + (s << 6) + (s >> 2));
    endfunction

    function automatic logic [63:0] entry_sum(cte_pkg::entry_t e);
        logic [63:0] s;
        s = hash_step(64'd0, e.id);
        s = hash_step(s, {60'd0, e.kind});
        s = hash_step(s, e.object);
        s = hash_step(s, {48'd0, e.rights});
        s = hash_step(s, {32'd0, e.owner});
        s = hash_step(s, e.created);
        return s;
    endfunction

    function automatic int find_slot(logic [63:0] id);
        if (id == 64'd0) return NUM_ENTRIES;
        for (int i = 0; i < NUM_ENTRIES; i++)
            if (cap_table[i].id == id) return i;
        return NUM_ENTRIES;
    endfunction

    function automatic logic [3:0] verify_cap(logic [63:0] id, logic [15:0] need,
                                              logic [31:0] caller);
        int i;
        i = find_slot(id);
        if (i >= NUM_ENTRIES) return cte_pkg::ST_NOT_FOUND;
        if (cap_table[i].status != cte_pkg::ENT_ACTIVE) return cte_pkg::ST_INACTIVE;
        if (cap_table[i].checksum != entry_sum(cap_table[i])) begin
            cap_table[i].status = cte_pkg::ENT_REVOKED;
            return cte_pkg::ST_INTEGRITY;
        end
        if (cap_table[i].owner != caller) return cte_pkg::ST_WRONG_OWN;
        if ((cap_table[i].rights & need) != need) return cte_pkg::ST_NO_RIGHTS;
        return cte_pkg::ST_OK;
    endfunction

    function automatic answer_t apply_request(logic [343:0] d);
        logic [1:0]  op;
        logic [63:0] cid, obj, now, rnd;
        logic [3:0]  kind;
        logic [15:0] rts;
        logic [31:0] owner, caller;
        answer_t     a;
        int          i;
        op     = d[1:0];
        cid    = d[65:2];
        kind   = d[69:66];
        obj    = d[133:70];
        rts    = d[149:134];
        owner  = d[181:150];
        caller = d[213:182];
        now    = d[277:214];
        rnd    = d[341:278];
        a = '0;
        case (op)
            cte_pkg::OP_CREATE: begin
                for (i = 0; i < NUM_ENTRIES; i++)
                    if (cap_table[i].status == cte_pkg::ENT_REVOKED) break;
                if (i >= NUM_ENTRIES) begin
                    a.status = cte_pkg::ST_FULL;
                end else begin
                    a.new_id = next_serial ^ rnd;
                    next_serial = next_serial + 64'd1;
                    cap_table[i].id       = a.new_id;
                    cap_table[i].kind     = kind;
                    cap_table[i].object   = obj;
                    cap_table[i].rights   = rts;
                    cap_table[i].owner    = owner;
                    cap_table[i].creator  = caller;
                    cap_table[i].created  = now;
                    cap_table[i].checksum = entry_sum(cap_table[i]);
                    cap_table[i].status   = cte_pkg::ENT_ACTIVE;
                end
            end
            cte_pkg::OP_CHECK: a.status = verify_cap(cid, rts, caller);
            cte_pkg::OP_DESTROY: begin
                i = find_slot(cid);
                if (i >= NUM_ENTRIES) begin
                    a.status = cte_pkg::ST_NOT_FOUND;
                end else if (cap_table[i].rights[cte_pkg::RIGHT_IMMORTAL]) begin
                    a.status = cte_pkg::ST_IMMORTAL;
                end else begin
                    cap_table[i].status = cte_pkg::ENT_REVOKED;
                    cap_table[i].id     = '0;
                    cap_table[i].rights = '0;
                    cap_table[i].owner  = '0;
                    cap_table[i].object = '0;
                end
            end
            default: begin
                a.status = verify_cap(cid, 16'(1 << cte_pkg::RIGHT_REVOKE), caller);
                if (a.status == cte_pkg::ST_OK) begin
                    for (i = 0; i < NUM_ENTRIES; i++) begin
                        if (cap_table[i].owner != owner
                            || cap_table[i].status != cte_pkg::ENT_ACTIVE) continue;
                        if (!(cap_table[i].object == 0
                              || cap_table[i].creator == caller)) continue;
                        if (cap_table[i].rights[cte_pkg::RIGHT_IMMORTAL]) continue;
                        cap_table[i].rights   = cap_table[i].rights & ~rts;
                        cap_table[i].checksum = entry_sum(cap_table[i]);
                        if (cap_table[i].rights == 0)
                            cap_table[i].status = cte_pkg::ENT_REVOKED;
                        if (a.revoked < 7'd127) a.revoked++;
                    end
                    if (a.revoked == 0) a.status = cte_pkg::ST_NONE_REV;
                end
            end
        endcase
        a.granted = (a.status == cte_pkg::ST_OK);
        return a;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch at %0t: %s got 0x%0h, expected 0x%0h", $time, what, got, want);
        fail_count++;
    endtask

    always @(posedge aclk) begin
        answer_t got, want;
        if (!aresetn) begin
            for (int i = 0; i < NUM_ENTRIES; i++) begin
                cap_table[i] = '0;
                cap_table[i].status = cte_pkg::ENT_REVOKED;
            end
            next_serial = cte_pkg::COUNTER_RESET;
            answer_q.delete();
            fail_count = 0;
        end else begin
            if (s_tvalid && s_tready)
                answer_q.push_back(apply_request(s_tdata));
            if (m_tvalid && m_tready) begin
                got = m_tdata[75:0];
                if (answer_q.size() == 0) begin
                    report_mismatch("unexpected response", m_tdata[63:0], 64'd0);
                end else begin
                    want = answer_q.pop_front();
                    if (got.status != want.status)
                        report_mismatch("status", 64'(got.status), 64'(want.status));
                    if (got.new_id != want.new_id)
                        report_mismatch("created id", got.new_id, want.new_id);
                    if (got.granted != want.granted)
                        report_mismatch("granted", 64'(got.granted), 64'(want.granted));
                    if (got.revoked != want.revoked)
                        report_mismatch("changed entry total", 64'(got.revoked),
                                        64'(want.revoked));
                end
            end
        end
        pending = answer_q.size();
    end

endmodule
`default_nettype wire

### verif/tb_capability_table_engine_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Capability table engine testbench
// Drives directed and random create, check, destroy and revoke requests with
// bursty input and a stalling receiver; a checker module predicts and compares.
// ----------------------------------------------------------------------------
module tb_capability_table_engine_core;

    localparam int NUM_ENTRIES = 64;
    localparam int IDLE_LIMIT  = 40000;
    localparam int RANDOM_REQS = 1500;

    typedef struct {
        logic [1:0]  op;
        logic [63:0] cap_id;
        logic [3:0]  kind;
        logic [63:0] object;
        logic [15:0] rights;
        logic [31:0] owner;
        logic [31:0] caller;
        logic [63:0] now;
        logic [63:0] rnd;
    } request_t;

    logic          aclk;
    logic          aresetn;
    logic          s_tvalid;
    logic          s_tready;
    logic [343:0]  s_tdata;
    logic          m_tvalid;
    logic          m_tready = 1'b0;
    logic [79:0]   m_tdata;
    int            fail_count;
    int            pending;
    int            idle_cycles;
    int            burst_left;
    int            stall_mode = 0;
    int            stall_cycle = 0;
    logic [63:0]   known_ids [$];
    logic [31:0]   pid_pool [4] = '{32'd1, 32'd2, 32'd3, 32'hFFFF_FFFF};

    capability_table_engine_core #(.NUM_ENTRIES(NUM_ENTRIES)) i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    cte_checker #(.NUM_ENTRIES(NUM_ENTRIES)) i_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(negedge aclk) begin
        stall_cycle <= stall_cycle + 1;
        if (stall_cycle % 300 == 0) stall_mode <= $urandom_range(0, 3);
        case (stall_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= ($urandom_range(0, 1) == 1);
            2: m_tready <= (stall_cycle % 17) < 4;
            default: m_tready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    always @(posedge aclk) begin
        if (m_tvalid && m_tready && m_tdata[68] && m_tdata[67:4] != 0) begin
            known_ids.push_back(m_tdata[67:4]);
            if (known_ids.size() > 96) void'(known_ids.pop_front());
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (s_tvalid || pending > 0) begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("[capability_table_engine_core] ERROR");
                $finish;
            end
        end
    end

    task automatic send(request_t r);
        s_tvalid <= 1'b1;
        s_tdata  <= {2'd0, r.rnd, r.now, r.caller, r.owner, r.rights, r.object,
                     r.kind, r.cap_id, r.op};
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 20);
            if ($urandom_range(0, 2) != 0) begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(negedge aclk);
            end
        end
    endtask

    function automatic request_t make_req(logic [1:0] op, logic [63:0] cap_id,
                                          logic [15:0] rights, logic [31:0] owner,
                                          logic [31:0] caller, logic [63:0] rnd,
                                          logic [63:0] object);
        request_t r;
        r.op     = op;
        r.cap_id = cap_id;
        r.kind   = 4'($urandom_range(0, 12));
        r.object = object;
        r.rights = rights;
        r.owner  = owner;
        r.caller = caller;
        r.now    = {$urandom, $urandom};
        r.rnd    = rnd;
        return r;
    endfunction

    function automatic request_t random_req();
        request_t r;
        int       pick;
        r.op     = 2'($urandom_range(0, 3));
        pick     = $urandom_range(0, 99);
        if (pick < 5) r.cap_id = '0;
        else if (pick < 15 || known_ids.size() == 0) r.cap_id = {$urandom, $urandom};
        else r.cap_id = known_ids[$urandom_range(0, known_ids.size() - 1)];
        r.kind   = 4'($urandom);
        r.object = $urandom_range(0, 2) == 0 ? 64'd0 : {$urandom, $urandom};
        r.rights = 16'($urandom);
        if (r.op == cte_pkg::OP_CHECK || r.op == cte_pkg::OP_REVOKE)
            r.rights &= 16'($urandom);
        if (r.op == cte_pkg::OP_CREATE) begin
            r.rights[cte_pkg::RIGHT_IMMORTAL] = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 1) == 1) r.rights[cte_pkg::RIGHT_REVOKE] = 1'b1;
        end
        r.owner  = $urandom_range(0, 9) == 0 ? $urandom : pid_pool[$urandom_range(0, 3)];
        r.caller = $urandom_range(0, 9) == 0 ? $urandom : pid_pool[$urandom_range(0, 3)];
        r.now    = {$urandom, $urandom};
        r.rnd    = {$urandom, $urandom};
        return r;
    endfunction

    initial begin
        logic [63:0] base;
        aresetn    = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        burst_left = 0;
        base       = cte_pkg::COUNTER_RESET;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // Directed: a duplicate id, every status code except the integrity failure, and the field extremes.
        send(make_req(cte_pkg::OP_CREATE, 0, 16'h0010, 1, 1, 0, 64'd5));
        send(make_req(cte_pkg::OP_CREATE, 0, 16'h0010, 2, 2, base ^ (base + 1), 64'd6));
        send(make_req(cte_pkg::OP_CHECK, base, 16'h0010, 0, 1, 0, 0));
        send(make_req(cte_pkg::OP_CHECK, base, 16'h0010, 0, 2, 0, 0));
        send(make_req(cte_pkg::OP_CHECK, base, 16'hFFFF, 0, 1, 0, 0));
        send(make_req(cte_pkg::OP_CHECK, 0, 16'h0000, 0, 1, 0, 0));
        send(make_req(cte_pkg::OP_CHECK, 64'hFFFF_FFFF_FFFF_FFFF, 0, 0, 1, 0, 0));
        send(make_req(cte_pkg::OP_CREATE, 0, 16'h4010, 1, 1, 0, 64'd7));
        send(make_req(cte_pkg::OP_DESTROY, base + 2, 0, 0, 1, 0, 0));
        send('{cte_pkg::OP_CREATE, '1, 4'hF, '1, 16'hFFFF, '1, '1, '1, '1});
        send(make_req(cte_pkg::OP_CREATE, 0, 16'h00FF, 1, 3, 0, 64'd0));
        send(make_req(cte_pkg::OP_REVOKE, base, 16'h00FF, 1, 1, 0, 0));
        send(make_req(cte_pkg::OP_CHECK, base + 4, 16'h0000, 0, 1, 0, 0));
        send(make_req(cte_pkg::OP_DESTROY, base + 4, 0, 0, 1, 0, 0));
        send(make_req(cte_pkg::OP_REVOKE, base, 16'h0001, 9, 1, 0, 0));
        send(make_req(cte_pkg::OP_REVOKE, base + 2, 16'h0001, 1, 1, 0, 0));
        send(make_req(cte_pkg::OP_CREATE, 0, 16'h0001, 1, 1, 0, 64'd8));
        send(make_req(cte_pkg::OP_REVOKE, base + 5, 16'h0001, 1, 1, 0, 0));
        send(make_req(cte_pkg::OP_DESTROY, base, 0, 0, 1, 0, 0));
        send(make_req(cte_pkg::OP_DESTROY, base, 0, 0, 1, 0, 0));
        send(make_req(cte_pkg::OP_CHECK, base, 16'h0010, 0, 2, 0, 0));
        send(make_req(cte_pkg::OP_DESTROY, 0, 0, 0, 0, 0, 0));
        repeat (70)
            send(make_req(cte_pkg::OP_CREATE, 0, 16'h0011, 2, 2,
                          {$urandom, $urandom}, 0));

        for (int n = 0; n < RANDOM_REQS; n++) send(random_req());
        s_tvalid <= 1'b0;

        while (pending > 0) @(negedge aclk);
        repeat (1000) @(negedge aclk);
        if (fail_count == 0) begin
            $display("[capability_table_engine_core] OK");
        end else begin
            $display("[capability_table_engine_core] ERROR");
        end
        $finish;
    end

endmodule
`default_nettype wire

### filelist.f
rtl/cte_pkg.sv
rtl/cte_table.sv
rtl/capability_table_engine_core.sv
verif/cte_checker.sv
verif/tb_capability_table_engine_core.sv
